/* rtl/core/rsa_byte_modular_exponentiation_core_assert.svh */
// assertion macros for the modular exponentiation core
`ifndef RSA_BYTE_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define RSA_BYTE_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RBME_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define RBME_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`else
`define RBME_ASSERT(label, clk, rst_n, prop)
`define RBME_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

/* rtl/core/rbme_pkg.sv */
// shared constants and beat type for the modular exponentiation core
`default_nettype none
package rbme_pkg;
	localparam int MOD_BITS = 16;
	localparam int EXP_BITS = 16;
	localparam int DATA_BITS = 8;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 1'b1;
	localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(127);
	localparam logic [EXP_BITS-1:0] EXP_RESET = EXP_BITS'(1);

	typedef struct packed {
		logic valid;
		logic last;
		logic [MOD_BITS-1:0] acc;
		logic [MOD_BITS-1:0] base;
	} beat_t;
endpackage
`default_nettype wire

/* rtl/core/rbme_reduce.sv */
// pipelined reduction of the input byte modulo the modulus, one bit per stage
`default_nettype none
module rbme_reduce (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_last,
	input  wire logic [rbme_pkg::DATA_BITS-1:0] in_data,
	input  wire logic [rbme_pkg::MOD_BITS-1:0]  m,
	output rbme_pkg::beat_t                   out_beat
);
	import rbme_pkg::*;

	logic                 valid_s [DATA_BITS];
	logic                 last_s  [DATA_BITS];
	logic [DATA_BITS-1:0] data_s  [DATA_BITS];
	logic [MOD_BITS-1:0]  rem_s   [DATA_BITS];

	for (genvar k = 0; k < DATA_BITS; k++) begin : g_stage
		logic                 v_in;
		logic                 l_in;
		logic [DATA_BITS-1:0] d_in;
		logic [MOD_BITS-1:0]  r_in;
		logic [MOD_BITS:0]    r_sh;
		logic [MOD_BITS:0]    r_nx;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign l_in = in_last;
			assign d_in = in_data;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = valid_s[k-1];
			assign l_in = last_s[k-1];
			assign d_in = data_s[k-1];
			assign r_in = rem_s[k-1];
		end

		always_comb begin
			r_sh = {r_in, d_in[DATA_BITS-1]};
			r_nx = (r_sh >= {1'b0, m}) ? (r_sh - {1'b0, m}) : r_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			last_s[k] <= l_in;
			data_s[k] <= {d_in[DATA_BITS-2:0], 1'b0};
			rem_s[k]  <= r_nx[MOD_BITS-1:0];
		end
	end

	always_comb begin
		out_beat.valid = valid_s[DATA_BITS-1];
		out_beat.last  = last_s[DATA_BITS-1];
		out_beat.acc   = MOD_BITS'(1);
		out_beat.base  = rem_s[DATA_BITS-1];
	end
endmodule
`default_nettype wire

/* rtl/core/rbme_modmul.sv */
// bit-serial interleaved modular multiply, one multiplier bit per stage
`default_nettype none
module rbme_modmul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rbme_pkg::beat_t             in_beat,
	input  wire logic                        square,
	input  wire logic                        en,
	input  wire logic [rbme_pkg::MOD_BITS-1:0] m,
	output rbme_pkg::beat_t                  out_beat
);
	import rbme_pkg::*;

	logic                valid_s [MOD_BITS];
	beat_t               beat_s  [MOD_BITS];
	logic [MOD_BITS-1:0] a_s     [MOD_BITS];
	logic [MOD_BITS-1:0] b_s     [MOD_BITS];
	logic [MOD_BITS-1:0] p_s     [MOD_BITS];

	for (genvar k = 0; k < MOD_BITS; k++) begin : g_stage
		logic                v_in;
		beat_t               bt_in;
		logic [MOD_BITS-1:0] a_in;
		logic [MOD_BITS-1:0] b_in;
		logic [MOD_BITS-1:0] p_in;
		logic [MOD_BITS:0]   p_dbl;
		logic [MOD_BITS:0]   p_red;
		logic [MOD_BITS:0]   p_add;
		logic [MOD_BITS:0]   p_nx;

		if (k == 0) begin : g_first
			assign v_in  = in_beat.valid;
			assign bt_in = in_beat;
			assign a_in  = in_beat.acc;
			assign b_in  = square ? in_beat.acc : in_beat.base;
			assign p_in  = '0;
		end else begin : g_next
			assign v_in  = valid_s[k-1];
			assign bt_in = beat_s[k-1];
			assign a_in  = a_s[k-1];
			assign b_in  = b_s[k-1];
			assign p_in  = p_s[k-1];
		end

		always_comb begin
			p_dbl = {p_in, 1'b0};
			p_red = (p_dbl >= {1'b0, m}) ? (p_dbl - {1'b0, m}) : p_dbl;
			p_add = a_in[MOD_BITS-1] ? (p_red + {1'b0, b_in}) : p_red;
			p_nx  = (p_add >= {1'b0, m}) ? (p_add - {1'b0, m}) : p_add;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			beat_s[k] <= bt_in;
			a_s[k]    <= {a_in[MOD_BITS-2:0], 1'b0};
			b_s[k]    <= b_in;
			p_s[k]    <= p_nx[MOD_BITS-1:0];
		end
	end

	always_comb begin
		out_beat       = beat_s[MOD_BITS-1];
		out_beat.valid = valid_s[MOD_BITS-1];
		out_beat.acc   = en ? p_s[MOD_BITS-1] : beat_s[MOD_BITS-1].acc;
	end
endmodule
`default_nettype wire

/* rtl/core/rsa_byte_modular_exponentiation_core.sv */
// top level: byte modular exponentiation, pipelined square-and-multiply
// throughput: one byte per cycle, busy stays low; each of the 2*EXP_BITS modular
// multiplies is a chain of MOD_BITS add-and-compare stages, one multiplier bit each
// results cannot be stalled: done is a one-cycle strobe
// reset clears the valid bits and loads modulus 127 and exponent 1
`default_nettype none
`include "rsa_byte_modular_exponentiation_core_assert.svh"
module rsa_byte_modular_exponentiation_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [rbme_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  wire logic [rbme_pkg::CFG_DATA_BITS-1:0] wr_data,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [rbme_pkg::DATA_BITS-1:0]     data_in,
	input  wire logic                             last_in,
	output logic                                  done,
	output logic [rbme_pkg::MOD_BITS-1:0]           residue,
	output logic                                  last_out
);
	import rbme_pkg::*;

	localparam int STEPS = 2 * EXP_BITS;

	logic [MOD_BITS-1:0] modulus_q;
	logic [EXP_BITS-1:0] exponent_q;
	logic                done_q;
	logic                last_q;
	logic [MOD_BITS-1:0] residue_q;
	beat_t               chain [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_RESET;
			exponent_q <= EXP_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODULUS:  modulus_q  <= MOD_BITS'(wr_data);
				REG_EXPONENT: exponent_q <= EXP_BITS'(wr_data);
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	rbme_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.in_last  (last_in),
		.in_data  (data_in),
		.m        (modulus_q),
		.out_beat (chain[0])
	);

	for (genvar i = 0; i < EXP_BITS; i++) begin : g_bit
		rbme_modmul u_sq (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_beat  (chain[2*i]),
			.square   (1'b1),
			.en       (1'b1),
			.m        (modulus_q),
			.out_beat (chain[2*i+1])
		);
		rbme_modmul u_mul (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_beat  (chain[2*i+1]),
			.square   (1'b0),
			.en       (exponent_q[EXP_BITS-1-i]),
			.m        (modulus_q),
			.out_beat (chain[2*i+2])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		last_q    <= chain[STEPS].last;
		residue_q <= (modulus_q < MOD_BITS'(2)) ? '0 : chain[STEPS].acc;
	end

	assign done     = done_q;
	assign residue  = residue_q;
	assign last_out = last_q;

	`RBME_ASSERT(a_no_busy, clk, arst_n, !busy)
	`RBME_ASSERT_NEXT(a_accept_enters, clk, arst_n, start, u_reduce.valid_s[0])
	`RBME_ASSERT_NEXT(a_small_mod_zero, clk, arst_n, chain[STEPS].valid && (modulus_q < MOD_BITS'(2)), done && (residue == '0))
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for the byte modular exponentiation core
`default_nettype none
module tb_top;
	import rbme_pkg::*;

	typedef struct {
		logic [DATA_BITS-1:0] data;
		logic last;
	} text_byte_t;

	typedef struct {
		logic [MOD_BITS-1:0] residue;
		logic last;
	} residue_beat_t;

	localparam int LATENCY = DATA_BITS + 2*EXP_BITS*MOD_BITS + 1;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_BITS-1:0] wr_index;
	logic [CFG_DATA_BITS-1:0] wr_data;
	logic start;
	logic busy;
	logic [DATA_BITS-1:0] data_in;
	logic last_in;
	logic done;
	logic [MOD_BITS-1:0] residue;
	logic last_out;

	text_byte_t pending_bytes[$];
	residue_beat_t expected_residues[$];
	logic [MOD_BITS-1:0] cur_modulus;
	logic [EXP_BITS-1:0] cur_exponent;
	int errors = 0;
	int cycles = 0;
	int gap = 0;
	bit no_idle = 0;

	rsa_byte_modular_exponentiation_core uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.start(start), .busy(busy), .data_in(data_in), .last_in(last_in),
		.done(done), .residue(residue), .last_out(last_out)
	);

	function automatic logic [MOD_BITS-1:0] power_mod(logic [DATA_BITS-1:0] b,
			logic [EXP_BITS-1:0] e, logic [MOD_BITS-1:0] m);
		longint unsigned acc;
		longint unsigned base;
		if (m < 2) return '0;
		base = b % m;
		acc = 1;
		for (int i = EXP_BITS-1; i >= 0; i--) begin
			acc = (acc * acc) % m;
			if (e[i]) acc = (acc * base) % m;
		end
		return acc[MOD_BITS-1:0];
	endfunction

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		text_byte_t item;
		bit fire;
		if (!arst_n) begin
			start <= 1'b0;
			data_in <= '0;
			last_in <= 1'b0;
		end else begin
			fire = start && !busy;
			if (fire)
				expected_residues.push_back('{power_mod(data_in, cur_exponent, cur_modulus),
					last_in});
			if (!start || fire) begin
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					item = pending_bytes.pop_front();
					data_in <= item.data;
					last_in <= item.last;
					start <= 1'b1;
					gap = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		residue_beat_t exp_beat;
		if (arst_n && done) begin
			if (expected_residues.size() == 0) begin
				report($sformatf("unexpected beat residue=%0d", residue));
			end else begin
				exp_beat = expected_residues.pop_front();
				if (residue !== exp_beat.residue)
					report($sformatf("residue %0d, expected %0d (n=%0d e=%0d)",
						residue, exp_beat.residue, cur_modulus, cur_exponent));
				if (last_out !== exp_beat.last)
					report($sformatf("last_out %0b, expected %0b", last_out, exp_beat.last));
			end
		end
	end

	task automatic set_key(logic [MOD_BITS-1:0] m, logic [EXP_BITS-1:0] e);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_MODULUS;
		wr_data <= m;
		@(posedge clk);
		wr_index <= REG_EXPONENT;
		wr_data <= e;
		@(posedge clk);
		wr_en <= 1'b0;
		cur_modulus = m;
		cur_exponent = e;
	endtask

	task automatic drain();
		while (pending_bytes.size() > 0 || start || expected_residues.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic push_byte(int d, bit l);
		pending_bytes.push_back('{d[DATA_BITS-1:0], l});
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++)
			push_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0);
	endtask

	initial begin
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		cur_modulus = MOD_RESET;
		cur_exponent = EXP_RESET;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset key, bytes at and around the modulus
		push_byte(0, 0); push_byte(255, 0); push_byte(126, 0); push_byte(127, 0);
		push_byte(128, 1); push_byte(1, 0);
		push_random(60);
		drain();

		set_key(2, 0);
		push_byte(0, 0); push_byte(255, 1); push_byte(3, 0);
		push_random(60);
		drain();

		no_idle = 1;
		set_key(16'hffff, 16'hffff);
		push_byte(255, 0); push_byte(254, 1); push_byte(0, 0); push_byte(1, 0);
		push_random(70);
		drain();
		no_idle = 0;

		set_key(1, 5);
		push_byte(200, 1); push_byte(0, 0);
		push_random(20);
		drain();

		set_key(0, 3);
		push_byte(7, 0); push_byte(255, 1);
		push_random(20);
		drain();

		set_key(3233, 17);
		push_byte(65, 0); push_byte(255, 1);
		push_random(70);
		drain();

		set_key(3233, 2753);
		push_random(70);
		drain();

		set_key(251, 0);
		push_random(40);
		drain();

		for (int p = 0; p < 5; p++) begin
			no_idle = (p == 2);
			set_key(MOD_BITS'($urandom_range(2, 65535)), EXP_BITS'($urandom_range(0, 65535)));
			push_random(70);
			drain();
		end
		no_idle = 0;

		set_key(MOD_RESET, EXP_RESET);
		push_random(30);
		drain();

		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_residues.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* rsa_byte_modular_exponentiation_core.f */
+incdir+rtl/core
rtl/core/rbme_pkg.sv
rtl/core/rbme_reduce.sv
rtl/core/rbme_modmul.sv
rtl/core/rsa_byte_modular_exponentiation_core.sv
dv/tb_top.sv
